>>> rtl/efs_pkg.sv
// Package with the payload types, widths and register map of the staircase unit.
`timescale 1ns / 1ps
`default_nettype none

package efs_pkg;

  localparam int COST_BITS   = 32;
  localparam int VERTEX_BITS = 16;
  localparam int SLACK_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  // The factor (1 + slack) in Q9.16 needs one bit more than the slack itself.
  localparam int FACTOR_BITS = SLACK_BITS + 1;
  localparam int PROD_BITS   = COST_BITS + FACTOR_BITS;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam logic [FACTOR_BITS-1:0] ONE_Q16 = FACTOR_BITS'(1) << FRAC_BITS;

  // Register indexes, taken from paddr[2].
  localparam logic REG_SLACK_FIRST  = 1'b0;
  localparam logic REG_SLACK_SECOND = 1'b1;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex_id;
    logic [COST_BITS-1:0]   cost_first;
    logic [COST_BITS-1:0]   cost_second;
    logic                   list_end;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex_out;
    logic [COST_BITS-1:0]   corner_first;
    logic [COST_BITS-1:0]   corner_second;
    logic                   final_corner;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/epsilon_front_staircase_unit.sv
// Top level of the epsilon front staircase unit: slack compare, held point and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Path: a corner passes through the stage-1 register and the result queue to out_data.
// Throughput: one input transaction per cycle unless stage 2 stalls; the output drains one
// corner per cycle while out_ready holds, so a run of items that cause two corners stalls the
// input once three of four queue entries fill.
// Reset: rst is synchronous and active high; it clears both slack registers, the held point,
// the kept-point count, the pipeline valid bit and the result queue. No clearing pass is needed.
module epsilon_front_staircase_unit (
  input  wire                            clk,
  input  wire                            rst,
  // Input point channel.
  input  wire                            in_valid,
  output logic                           in_ready,
  input  efs_pkg::in_item_t              in_data,
  // Corner channel.
  output logic                           out_valid,
  input  wire                            out_ready,
  output efs_pkg::out_item_t             out_data,
  // APB-style configuration port.
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [efs_pkg::ADDR_BITS-1:0]   paddr,
  input  wire [efs_pkg::DATA_BITS-1:0]   pwdata,
  output logic [efs_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  localparam int CB = efs_pkg::COST_BITS;
  localparam int PB = efs_pkg::PROD_BITS;
  localparam int QDEPTH = 4;
  localparam int QPTR = $clog2(QDEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands on the access cycle of the transfer.
  // ---------------------------------------------------------------------------
  logic [efs_pkg::SLACK_BITS-1:0] slack_first;
  logic [efs_pkg::SLACK_BITS-1:0] slack_second;
  logic                           cfg_write;

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slack_first  <= '0;
      slack_second <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == efs_pkg::REG_SLACK_FIRST) begin
        slack_first <= pwdata[efs_pkg::SLACK_BITS-1:0];
      end else begin
        slack_second <= pwdata[efs_pkg::SLACK_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == efs_pkg::REG_SLACK_FIRST) begin
      prdata = efs_pkg::DATA_BITS'(slack_first);
    end else begin
      prdata = efs_pkg::DATA_BITS'(slack_second);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the slack products depend only on the incoming point, so they are
  // formed as the transaction is accepted and registered with the point.
  // ---------------------------------------------------------------------------
  logic [efs_pkg::FACTOR_BITS-1:0] factor_first;
  logic [efs_pkg::FACTOR_BITS-1:0] factor_second;
  logic [PB-1:0]                   prod_first_next;
  logic [PB-1:0]                   prod_second_next;

  assign factor_first     = efs_pkg::ONE_Q16 + efs_pkg::FACTOR_BITS'(slack_first);
  assign factor_second    = efs_pkg::ONE_Q16 + efs_pkg::FACTOR_BITS'(slack_second);
  assign prod_first_next  = PB'(in_data.cost_first) * PB'(factor_first);
  assign prod_second_next = PB'(in_data.cost_second) * PB'(factor_second);

  logic              s1_valid;
  efs_pkg::in_item_t s1_item;
  logic [PB-1:0]     prod_first;
  logic [PB-1:0]     prod_second;
  logic              s1_fire;
  logic              in_fire;

  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item     <= in_data;
      prod_first  <= prod_first_next;
      prod_second <= prod_second_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: compare against the held point, update the staircase state and
  // push zero, one or two corners into the result queue.
  // ---------------------------------------------------------------------------
  logic [CB-1:0] earlier_first;
  logic [CB-1:0] held_first;
  logic [CB-1:0] held_second;
  logic [1:0]    kept_count;

  logic [CB-1:0] earlier_first_next;
  logic [CB-1:0] held_first_next;
  logic [CB-1:0] held_second_next;
  logic [1:0]    kept_count_next;

  logic               within_first;
  logic               within_second;
  logic               push_corner;
  efs_pkg::out_item_t push_item;
  efs_pkg::out_item_t end_item;

  // held * 2^16 against (1 + slack) * incoming, both exact at full width.
  assign within_first  = (PB'(held_first) << efs_pkg::FRAC_BITS) <= prod_first;
  assign within_second = (PB'(held_second) << efs_pkg::FRAC_BITS) <= prod_second;

  always_comb begin
    earlier_first_next = earlier_first;
    held_first_next    = held_first;
    held_second_next   = held_second;
    kept_count_next    = kept_count;
    push_corner        = 1'b0;

    push_item.vertex_out    = s1_item.vertex_id;
    push_item.corner_first  = earlier_first;
    push_item.corner_second = held_second;
    push_item.final_corner  = 1'b0;

    if (kept_count == 2'd0) begin
      held_first_next  = s1_item.cost_first;
      held_second_next = s1_item.cost_second;
      kept_count_next  = 2'd1;
    end else if (within_first && within_second) begin
      // The held point absorbs the incoming one and takes its second cost.
      held_second_next = s1_item.cost_second;
    end else begin
      // The held point is pushed; the corner before it is now settled.
      push_corner        = (kept_count == 2'd2);
      earlier_first_next = held_first;
      held_first_next    = s1_item.cost_first;
      held_second_next   = s1_item.cost_second;
      kept_count_next    = 2'd2;
    end

    end_item.vertex_out    = s1_item.vertex_id;
    end_item.corner_first  = (kept_count_next == 2'd1) ? held_first_next : earlier_first_next;
    end_item.corner_second = held_second_next;
    end_item.final_corner  = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result queue. Stage 2 only advances when two entries are free, so a point
  // that gives two corners never overruns it.
  // ---------------------------------------------------------------------------
  efs_pkg::out_item_t queue [QDEPTH];
  logic [QPTR-1:0]    wr_ptr;
  logic [QPTR-1:0]    rd_ptr;
  logic [QPTR:0]      count;
  logic [QPTR:0]      count_next;
  logic               out_fire;
  logic               end_push;
  logic [QPTR:0]      push_num;

  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];
  assign out_fire  = out_valid && out_ready;
  assign s1_fire   = s1_valid && (count <= (QPTR+1)'(QDEPTH - 2));
  assign end_push  = s1_fire && s1_item.list_end;
  assign push_num  = (QPTR+1)'(s1_fire && push_corner) + (QPTR+1)'(end_push);
  assign count_next = count + push_num - (QPTR+1)'(out_fire);

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (push_corner) begin
        queue[wr_ptr] <= push_item;
        if (s1_item.list_end) begin
          queue[wr_ptr + QPTR'(1)] <= end_item;
        end
      end else if (s1_item.list_end) begin
        queue[wr_ptr] <= end_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR'(push_num);
      if (out_fire) begin
        rd_ptr <= rd_ptr + QPTR'(1);
      end
      count <= count_next;
    end
  end

  // State update; list end returns everything to the empty state.
  always_ff @(posedge clk) begin
    if (rst) begin
      earlier_first <= '0;
      held_first    <= '0;
      held_second   <= '0;
      kept_count    <= 2'd0;
    end else if (s1_fire) begin
      if (s1_item.list_end) begin
        earlier_first <= '0;
        held_first    <= '0;
        held_second   <= '0;
        kept_count    <= 2'd0;
      end else begin
        earlier_first <= earlier_first_next;
        held_first    <= held_first_next;
        held_second   <= held_second_next;
        kept_count    <= kept_count_next;
      end
    end
  end

endmodule

`default_nettype wire
